// ----- src/lpde_pkg.sv -----
// shared constants and rounding and saturation helpers for the legendre evaluator
// no dependencies
package lpde_pkg;

	localparam int MAX_ORDER_DEF = 15;
	localparam int ORDER_W = 4;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;
	localparam int Z_W = 18;
	localparam int VAL_W = 32;
	localparam int WIDE_W = 80;
	localparam int MUL_A_W = 41;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_W = 55;
	localparam int DM_W = 35;
	localparam int INV_W = 38;
	localparam int INV_HALF = 19;
	localparam int RECIP_W = 25;

	// round to nearest, halves away from zero, then shift right by s
	function automatic logic signed [WIDE_W-1:0] rnd_sh(input logic signed [WIDE_W-1:0] x,
		input int unsigned s);
		logic [WIDE_W-1:0] mag;
		logic [WIDE_W-1:0] r;
		mag = x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
		r = (mag + (WIDE_W'(1) << (s - 1))) >> s;
		return x[WIDE_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
		if (x > WIDE_W'(signed'(32'h7fff_ffff))) return 32'sh7fff_ffff;
		if (x < -(WIDE_W'(64'sh8000_0000))) return 32'sh8000_0000;
		return x[VAL_W-1:0];
	endfunction

endpackage

// ----- src/legendre_poly_and_derivative_eval.sv -----
// legendre polynomial and derivative evaluator, one shared multiplier and a
// bit-serial reciprocal under one sequencer; depends on lpde_pkg
//
// sequence: the reciprocal of 1 - z^2 is formed first, one quotient bit per cycle, and is
//   skipped at z = +1 and -1; then each degree from 0 to the order is formed in turn on
//   the single multiplier and held as a beat until taken, so output stalls hold it up; a
//   new point is taken only after the last degree's beat has gone
// reset: arst_n clears the sequencer and sets the order register to 4
module legendre_poly_and_derivative_eval
	import lpde_pkg::*;
#(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // z[17:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // degree[3:0], poly_value[35:4], deriv_value[67:36], zero pad
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	localparam int NW = $clog2(MAX_ORDER + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_DIV, ST_DEG, ST_M1, ST_M2, ST_M3, ST_M4,
		ST_PD, ST_D1, ST_D2, ST_D3, ST_D4, ST_OUT
	} state_t;

	state_t state_q;
	logic [ORDER_W-1:0] order_q;
	logic signed [Z_W-1:0] z_q;
	logic [NW-1:0] n_q, ord_q;
	logic atp_q, atn_q, dneg_q, qneg_q;
	logic [DM_W-1:0] dm_q;
	logic [DIV_W-1:0] divn_q;
	logic [DM_W:0] rem_q;
	logic [5:0] cnt_q;
	logic [INV_W-1:0] inv_q;
	logic signed [MUL_A_W-1:0] t_q;
	logic signed [WIDE_W-1:0] acc_q;
	logic signed [VAL_W-1:0] p_q, dv_q, pm1_q, pm2_q;

	// constant reciprocal table, round(2^24/n)
	logic [RECIP_W-1:0] recip_tab [MAX_ORDER+1];
	for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_recip
		localparam int D = (g == 0) ? 1 : g;
		localparam longint RV = ((longint'(1) << 24) + D / 2) / D;
		assign recip_tab[g] = RECIP_W'(RV);
	end

	// shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod;
	logic signed [WIDE_W-1:0] prod_w;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				mul_a = MUL_A_W'(z_q);
				mul_b = MUL_B_W'(z_q);
			end
			ST_M1: begin
				mul_a = MUL_A_W'(pm1_q);
				mul_b = signed'(MUL_B_W'({n_q, 1'b0} - 1'b1));
			end
			ST_M2, ST_D1: begin
				mul_a = (state_q == ST_M2) ? t_q : MUL_A_W'(p_q);
				mul_b = MUL_B_W'(z_q);
			end
			ST_M3: begin
				mul_a = MUL_A_W'(pm2_q);
				mul_b = signed'(MUL_B_W'(n_q - 1'b1));
			end
			ST_M4: begin
				mul_a = t_q;
				mul_b = signed'(MUL_B_W'(recip_tab[n_q]));
			end
			ST_D2: begin
				mul_a = t_q;
				mul_b = signed'(MUL_B_W'(n_q));
			end
			ST_D3: begin
				mul_a = t_q;
				mul_b = signed'(MUL_B_W'(inv_q[INV_HALF-1:0]));
			end
			ST_D4: begin
				mul_a = t_q;
				mul_b = signed'(MUL_B_W'(inv_q[INV_W-1:INV_HALF]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign prod_w = WIDE_W'(prod);

	// per-state datapath terms
	logic signed [WIDE_W-1:0] dd, num, n16, mterm, total, rr;
	logic [DM_W-1:0] dmag;
	logic [DM_W:0] rem2;
	logic ge;
	logic [2*NW:0] tri_n;
	logic signed [VAL_W-1:0] ep_dv, dv_mul;
	logic [WIDE_W-1:0] rmag;
	logic [NW-1:0] ord_eff;

	always_comb begin
		dd = (WIDE_W'(1) <<< 32) - prod_w;
		dmag = dd[WIDE_W-1] ? DM_W'(-dd) : DM_W'(dd);
		rem2 = {rem_q[DM_W-1:0], divn_q[DIV_W-1]};
		ge = rem2 >= {1'b0, dm_q};
		num = acc_q - (prod_w <<< 16);
		n16 = rnd_sh(num, 16);
		if (n16 > (WIDE_W'(1) <<< 38)) n16 = WIDE_W'(1) <<< 38;
		if (n16 < -(WIDE_W'(1) <<< 38)) n16 = -(WIDE_W'(1) <<< 38);
		mterm = WIDE_W'(pm1_q) - rnd_sh(prod_w, 16);
		total = acc_q + (prod_w <<< INV_HALF);
		rmag = WIDE_W'((total + (WIDE_W'(1) <<< 21)) >>> 22);
		if (qneg_q ^ dneg_q)
			rr = -$signed(rmag);
		else
			rr = $signed(rmag);
		dv_mul = sat32(rr);
		tri_n = (2*NW+1)'(n_q) * (2*NW+1)'(n_q + 1'b1);
		ep_dv = VAL_W'(tri_n >> 1) <<< 16;
		if (atn_q && !n_q[0]) ep_dv = -ep_dv;
		if (32'(order_q) > MAX_ORDER) ord_eff = NW'(MAX_ORDER);
		else ord_eff = NW'(order_q);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast = (n_q == ord_q);
	assign m_tdata = {4'd0, dv_q, p_q, 4'(n_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= ORDER_RESET;
			n_q <= '0;
			cnt_q <= '0;
			z_q <= '0;
			atp_q <= 1'b0;
			atn_q <= 1'b0;
			dneg_q <= 1'b0;
			qneg_q <= 1'b0;
			ord_q <= '0;
			dm_q <= '0;
			divn_q <= '0;
			rem_q <= '0;
			inv_q <= '0;
			t_q <= '0;
			acc_q <= '0;
			p_q <= '0;
			dv_q <= '0;
			pm1_q <= '0;
			pm2_q <= '0;
		end else begin
			if (cfg_valid) order_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						z_q <= s_tdata[Z_W-1:0];
						atp_q <= (s_tdata[Z_W-1:0] == Z_W'(65536));
						atn_q <= (s_tdata[Z_W-1:0] == Z_W'(-65536));
						ord_q <= ord_eff;
						n_q <= '0;
						pm1_q <= '0;
						pm2_q <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					dm_q <= dmag;
					dneg_q <= dd[WIDE_W-1];
					divn_q <= (DIV_W'(1) << 54) + DIV_W'(dmag >> 1);
					rem_q <= '0;
					cnt_q <= 6'(DIV_W);
					inv_q <= '0;
					state_q <= (atp_q || atn_q) ? ST_DEG : ST_DIV;
				end
				ST_DIV: begin
					// restoring divide, quotient shifts into the dividend register
					rem_q <= ge ? rem2 - {1'b0, dm_q} : rem2;
					divn_q <= {divn_q[DIV_W-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 6'd1) begin
						inv_q <= {divn_q[INV_W-2:0], ge};
						state_q <= ST_DEG;
					end
				end
				ST_DEG: begin
					if (n_q == '0) begin
						p_q <= 32'sd65536;
						state_q <= ST_PD;
					end else if (n_q == NW'(1)) begin
						p_q <= VAL_W'(z_q);
						state_q <= ST_PD;
					end else begin
						state_q <= ST_M1;
					end
				end
				ST_M1: begin
					t_q <= prod[MUL_A_W-1:0];
					state_q <= ST_M2;
				end
				ST_M2: begin
					acc_q <= prod_w;
					state_q <= ST_M3;
				end
				ST_M3: begin
					t_q <= n16[MUL_A_W-1:0];
					state_q <= ST_M4;
				end
				ST_M4: begin
					p_q <= sat32(rnd_sh(prod_w, 24));
					state_q <= ST_PD;
				end
				ST_PD: begin
					if (n_q == '0) begin
						dv_q <= '0;
						state_q <= ST_OUT;
					end else if (atp_q || atn_q) begin
						dv_q <= ep_dv;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_D1;
					end
				end
				ST_D1: begin
					t_q <= mterm[MUL_A_W-1:0];
					state_q <= ST_D2;
				end
				ST_D2: begin
					// magnitude of n*m, sign kept apart
					qneg_q <= prod[MUL_P_W-1];
					t_q <= prod[MUL_P_W-1] ? MUL_A_W'(-prod) : MUL_A_W'(prod);
					state_q <= ST_D3;
				end
				ST_D3: begin
					acc_q <= prod_w;
					state_q <= ST_D4;
				end
				ST_D4: begin
					dv_q <= dv_mul;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						pm2_q <= pm1_q;
						pm1_q <= p_q;
						if (n_q == ord_q) begin
							state_q <= ST_IDLE;
						end else begin
							n_q <= n_q + 1'b1;
							state_q <= ST_DEG;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");
	a_no_beat_while_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("result beat while accepting input");
	a_degree_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> n_q <= ord_q)
		else $error("degree past configured order");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("divide count ran out");
`endif

endmodule

// ----- bench/tb_legendre_poly_and_derivative_eval.sv -----
// self-checking bench for the legendre polynomial and derivative evaluator:
// streams points through the block, predicts every degree's result, checks each beat
// depends on lpde_pkg and legendre_poly_and_derivative_eval
module tb_legendre_poly_and_derivative_eval;
	import lpde_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [3:0]        degree;
		logic signed [31:0] poly;
		logic signed [31:0] deriv;
		logic              last;
	} leg_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;

	legendre_poly_and_derivative_eval dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	logic [Z_W-1:0] point_queue[$];
	leg_result_t    expected_results[$];
	logic [3:0]     order_reg = ORDER_RESET;
	logic [Z_W-1:0] cur_point = '0;
	int             errors = 0;
	int             points_sent = 0;
	int             beats_seen = 0;
	int             in_gap = 0;
	int             out_stall = 0;
	int             quiet_cycles = 0;
	bit             burst_mode = 1'b0;

	initial forever #10 clk = ~clk;

	function automatic longint round_shift(longint x, int s);
		longint unsigned m, r;
		m = (x < 0) ? longint'(-x) : x;
		r = (m + (64'd1 << (s - 1))) >> s;
		return (x < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint scale_by_inverse(longint q, longint inv);
		longint unsigned a, b, r;
		bit neg;
		a = (q < 0) ? longint'(-q) : q;
		b = (inv < 0) ? longint'(-inv) : inv;
		neg = (q < 0) != (inv < 0);
		if (a == 0 || b == 0) return 0;
		if (b > (64'hFFFF_FFFF_FFFF_FFFF - (64'd1 << 21)) / a)
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		r = (a * b + (64'd1 << 21)) >> 22;
		if (neg) return (r > (64'd1 << 31)) ? -64'sd2147483648 : -longint'(r);
		return (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
	endfunction

	// all degree results for one point at the current order
	task automatic predict_degrees(input logic [Z_W-1:0] zraw);
		longint z, pm1, pm2, p, dv, num, n16, d, m, inv;
		longint unsigned dm;
		int ord;
		bit at_pos, at_neg;
		leg_result_t r;
		z = longint'($signed(zraw));
		ord = (order_reg > MAX_ORDER_DEF) ? MAX_ORDER_DEF : order_reg;
		at_pos = (z == 65536);
		at_neg = (z == -65536);
		pm1 = 0;
		pm2 = 0;
		inv = 0;
		if (!(at_pos || at_neg)) begin
			d = (64'sd1 <<< 32) - z * z;
			dm = (d < 0) ? longint'(-d) : d;
			inv = longint'(((64'd1 << 54) + dm / 2) / dm);
			if (d < 0) inv = -inv;
		end
		for (int n = 0; n <= ord; n++) begin
			if (n == 0) p = 65536;
			else if (n == 1) p = z;
			else begin
				num = longint'(2 * n - 1) * (z * pm1) - longint'(n - 1) * (pm2 * 65536);
				n16 = round_shift(num, 16);
				if (n16 > (64'sd1 <<< 38)) n16 = 64'sd1 <<< 38;
				if (n16 < -(64'sd1 <<< 38)) n16 = -(64'sd1 <<< 38);
				p = clamp32(round_shift(n16 * longint'(((64'd1 << 24) + n / 2) / n), 24));
			end
			if (n == 0) dv = 0;
			else if (at_pos || at_neg) begin
				dv = clamp32(longint'(n * (n + 1) / 2) * 65536);
				if (at_neg && (n % 2) == 0) dv = -dv;
			end else begin
				m = pm1 - round_shift(z * p, 16);
				dv = scale_by_inverse(longint'(n) * m, inv);
			end
			r.degree = n[3:0];
			r.poly = p[31:0];
			r.deriv = dv[31:0];
			r.last = (n == ord);
			expected_results.push_back(r);
			pm2 = pm1;
			pm1 = p;
		end
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_degrees(cur_point);
				points_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					s_tvalid <= 1'b0;
				end else if (point_queue.size() > 0) begin
					cur_point <= point_queue[0];
					s_tdata <= {6'b0, point_queue.pop_front()};
					s_tvalid <= 1'b1;
					in_gap <= burst_mode ? 0 : $urandom_range(0, 5);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		leg_result_t exp_r;
		logic [3:0]  got_deg;
		logic [31:0] got_poly, got_deriv;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				got_deg = m_tdata[3:0];
				got_poly = m_tdata[35:4];
				got_deriv = m_tdata[67:36];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected beat deg=%0d poly=%h deriv=%h",
						$realtime, got_deg, got_poly, got_deriv);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got_deg !== exp_r.degree || got_poly !== exp_r.poly ||
						got_deriv !== exp_r.deriv || m_tlast !== exp_r.last) begin
						$display("%0t: mismatch exp deg=%0d poly=%h deriv=%h last=%b",
							$realtime, exp_r.degree, exp_r.poly, exp_r.deriv, exp_r.last);
						$display("%0t:          got deg=%0d poly=%h deriv=%h last=%b",
							$realtime, got_deg, got_poly, got_deriv, m_tlast);
						errors++;
					end
				end
				out_stall <= burst_mode ? 0 : $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 5000) begin
			$display("%0t: watchdog expired", $realtime);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_order(input logic [3:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		order_reg = v;
		cfg_valid <= 1'b0;
	endtask

	// checked at the falling edge so that every clocked update has settled
	task automatic drain();
		do @(negedge clk);
		while (point_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [Z_W-1:0] random_point();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 8) return Z_W'($urandom_range(0, 131072) - 65536);
		if (sel == 8) return Z_W'($urandom_range(0, 1) ? 65536 : -65536);
		return Z_W'($urandom);
	endfunction

	initial begin
		int dir_pts[$];
		dir_pts = '{0, 65536, -65536, 65535, -65535, 1, -1, 131071, -131072,
			32768, -32768, 46341, -46341, 70000, -100000, 12345};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		// reset order, a few points
		point_queue.push_back(Z_W'(30000));
		point_queue.push_back(Z_W'(-65536));
		drain();
		write_order(4'd0);
		point_queue.push_back(Z_W'(0));
		point_queue.push_back(Z_W'(65536));
		point_queue.push_back(Z_W'(-131072));
		drain();
		write_order(4'd15);
		foreach (dir_pts[i]) point_queue.push_back(Z_W'(dir_pts[i]));
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			burst_mode = (ph % 3 == 2);
			case (ph)
				0: write_order(4'd1);
				1: write_order(4'd2);
				2: write_order(4'd15);
				3: write_order(4'd0);
				default: write_order(4'($urandom_range(0, 15)));
			endcase
			for (int i = 0; i < 30; i++) point_queue.push_back(random_point());
			drain();
		end
		burst_mode = 1'b0;
		repeat (300) @(posedge clk);
		$display("covered %0d points and %0d result beats over several orders",
			points_sent, beats_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d errors, %0d results outstanding", errors, expected_results.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- legendre_poly_and_derivative_eval.f -----
src/lpde_pkg.sv
src/legendre_poly_and_derivative_eval.sv
bench/tb_legendre_poly_and_derivative_eval.sv
